/* sv/acf_pkg.sv */
// Shared types, constants and helper functions for the abbreviated count formatter.
package acf_pkg;

    localparam int VALUE_BITS_DEF = 48;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [63:0] TIER_B_MIN    = 64'd1000000000;
    localparam logic [63:0] TIER_M_MIN    = 64'd1000000;
    localparam logic [63:0] TIER_K_MIN    = 64'd1000;
    localparam logic [63:0] NEG_MAG_LIMIT = 64'd999999999999999;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_DOT   = 7'h2E;
    localparam logic [6:0] CHAR_K     = 7'h4B;
    localparam logic [6:0] CHAR_M     = 7'h4D;
    localparam logic [6:0] CHAR_B     = 7'h42;

    typedef enum logic [1:0] {
        TIER_NONE,
        TIER_K,
        TIER_M,
        TIER_B
    } tier_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT,
        ST_DOT,
        ST_FRAC,
        ST_SUFFIX
    } state_t;

    typedef struct packed {
        logic  neg;
        tier_t tier;
    } ctl_t;

    // Half of the tenths unit, added ahead of conversion for half-up rounding.
    function automatic logic [63:0] tier_half_unit(input tier_t tier);
        logic [63:0] half;
        case (tier)
            TIER_B:  half = 64'd50000000;
            TIER_M:  half = 64'd50000;
            TIER_K:  half = 64'd50;
            default: half = 64'd0;
        endcase
        return half;
    endfunction

    // Decimal position of the lowest digit of the integer part.
    function automatic logic [3:0] tier_low_pos(input tier_t tier);
        logic [3:0] pos;
        case (tier)
            TIER_B:  pos = 4'd9;
            TIER_M:  pos = 4'd6;
            TIER_K:  pos = 4'd3;
            default: pos = 4'd0;
        endcase
        return pos;
    endfunction

    function automatic logic [6:0] tier_suffix(input tier_t tier);
        logic [6:0] ch;
        case (tier)
            TIER_B:  ch = CHAR_B;
            TIER_M:  ch = CHAR_M;
            TIER_K:  ch = CHAR_K;
            default: ch = CHAR_ZERO;
        endcase
        return ch;
    endfunction

endpackage

/* sv/acf_front.sv */
// Front part: takes input items, classifies them and prepares the value to convert.
module acf_front
    import acf_pkg::*;
#(
    parameter int VB = VALUE_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [VB-1:0] count_value,
    input  logic          q_full,
    output logic          q_push,
    output ctl_t          q_ctl,
    output logic [VB-1:0] q_value
);

    localparam int WIDE = (VB > 50) ? VB : 50;

    logic          hold_valid_reg;
    logic          hold_valid_next;
    logic [VB-1:0] hold_value_reg;
    logic          in_accept;
    logic          neg;
    logic [VB-1:0] neg_mag;
    logic [WIDE-1:0] neg_mag_wide;
    logic          neg_sat;
    logic [VB-1:0] mag_sat;
    tier_t         tier;
    logic [VB-1:0] rounded;

    assign in_stall  = hold_valid_reg && q_full;
    assign in_accept = in_valid && !in_stall;
    assign q_push    = hold_valid_reg && !q_full;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hold_value_reg <= count_value;
        end
    end

    // Classify unrounded values; negatives go out in full, capped at NEG_MAG_LIMIT.
    assign neg          = hold_value_reg[VB-1];
    assign neg_mag      = ~hold_value_reg + {{(VB-1){1'b0}}, 1'b1};
    assign neg_mag_wide = WIDE'(neg_mag);
    assign neg_sat      = neg_mag_wide > WIDE'(NEG_MAG_LIMIT);
    assign mag_sat      = neg_sat ? VB'(NEG_MAG_LIMIT) : neg_mag;

    always_comb
    begin
        if (neg)
        begin
            tier = TIER_NONE;
        end
        else if (hold_value_reg >= VB'(TIER_B_MIN))
        begin
            tier = TIER_B;
        end
        else if (hold_value_reg >= VB'(TIER_M_MIN))
        begin
            tier = TIER_M;
        end
        else if (hold_value_reg >= VB'(TIER_K_MIN))
        begin
            tier = TIER_K;
        end
        else
        begin
            tier = TIER_NONE;
        end
    end

    // Pre-add half a tenth so that truncating digits later rounds half up.
    assign rounded    = hold_value_reg + VB'(tier_half_unit(tier));
    assign q_ctl.neg  = neg;
    assign q_ctl.tier = tier;
    assign q_value    = neg ? mag_sat : rounded;

endmodule

/* sv/acf_queue.sv */
// Two-entry queue between the front and back parts.
module acf_queue
    import acf_pkg::*;
#(
    parameter int VB = VALUE_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ctl_t          push_ctl,
    input  logic [VB-1:0] push_value,
    output logic          full,
    input  logic          pop,
    output logic          rd_valid,
    output ctl_t          rd_ctl,
    output logic [VB-1:0] rd_value
);

    localparam int PTRW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    ctl_t          ctl_mem [QUEUE_DEPTH];
    logic [VB-1:0] val_mem [QUEUE_DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [PTRW-1:0] rd_ptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;

    assign full     = count_reg == CNTW'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_ctl   = ctl_mem[rd_ptr_reg];
    assign rd_value = val_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg] <= push_ctl;
            val_mem[wr_ptr_reg] <= push_value;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");
`endif

endmodule

/* sv/acf_back.sv */
// Back part: binary to decimal conversion and character emission.
module acf_back
    import acf_pkg::*;
#(
    parameter int VB = VALUE_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_pop,
    input  ctl_t          q_ctl,
    input  logic [VB-1:0] q_value,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [6:0]    char_code,
    output logic          last_char
);

    localparam int NDIG = (VB * 30103) / 100000 + 1;
    localparam int BCDW = NDIG * 4;
    localparam int IDXW = $clog2(NDIG);
    localparam int CNTW = $clog2(VB);

    state_t          state_reg;
    state_t          state_next;
    ctl_t            ctl_reg;
    ctl_t            ctl_next;
    logic [VB-1:0]   bin_reg;
    logic [VB-1:0]   bin_next;
    logic [BCDW-1:0] bcd_reg;
    logic [BCDW-1:0] bcd_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic [IDXW-1:0] idx_reg;
    logic [IDXW-1:0] idx_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [6:0]      char_reg;
    logic [6:0]      char_next;
    logic            last_reg;
    logic            last_next;

    logic [BCDW-1:0] bcd_adj;
    logic [BCDW-1:0] bcd_shift;
    logic [3:0]      top_digit;
    logic [IDXW-1:0] low_pos;
    logic            load;
    logic            emit;
    logic [6:0]      emit_char;
    logic            emit_last;

    assign top_digit = bcd_reg[BCDW-1 -: 4];
    assign bcd_shift = {bcd_reg[BCDW-5:0], 4'd0};
    assign low_pos   = IDXW'(tier_low_pos(ctl_reg.tier));
    assign load      = !out_valid_reg || !out_stall;

    // Add 3 to every digit of 5 or more before each shift.
    always_comb
    begin
        for (int d = 0; d < NDIG; d++)
        begin
            bcd_adj[d*4 +: 4] = (bcd_reg[d*4 +: 4] >= 4'd5) ? bcd_reg[d*4 +: 4] + 4'd3
                                                            : bcd_reg[d*4 +: 4];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl_next   = ctl_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        emit_char  = CHAR_ZERO;
        emit_last  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    ctl_next   = q_ctl;
                    bin_next   = q_value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    idx_next   = IDXW'(NDIG - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[BCDW-2:0], bin_reg[VB-1]};
                bin_next = {bin_reg[VB-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(VB - 1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros down to the lowest integer digit.
                if (top_digit == 4'd0 && idx_reg > low_pos)
                begin
                    bcd_next = bcd_shift;
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    state_next = ctl_reg.neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (load)
                begin
                    emit       = 1'b1;
                    emit_char  = CHAR_MINUS;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (load)
                begin
                    emit      = 1'b1;
                    emit_char = CHAR_ZERO | {3'd0, top_digit};
                    bcd_next  = bcd_shift;
                    idx_next  = idx_reg - 1'b1;
                    if (idx_reg == low_pos)
                    begin
                        if (ctl_reg.tier == TIER_NONE)
                        begin
                            emit_last  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_DOT;
                        end
                    end
                end
            end
            ST_DOT:
            begin
                if (load)
                begin
                    emit       = 1'b1;
                    emit_char  = CHAR_DOT;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (load)
                begin
                    emit       = 1'b1;
                    emit_char  = CHAR_ZERO | {3'd0, top_digit};
                    bcd_next   = bcd_shift;
                    state_next = ST_SUFFIX;
                end
            end
            ST_SUFFIX:
            begin
                if (load)
                begin
                    emit       = 1'b1;
                    emit_char  = tier_suffix(ctl_reg.tier);
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            char_next      = emit_char;
            last_next      = emit_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg  <= ctl_next;
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

`ifndef SYNTHESIS
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIGIT || state_reg == ST_FRAC) && load) |-> top_digit <= 4'd9)
        else $error("non-decimal digit emitted");

    a_suffix_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUFFIX && load) |=>
            (out_valid && last_char &&
             (char_code == CHAR_K || char_code == CHAR_M || char_code == CHAR_B)))
        else $error("suffix item not flagged as last");

    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP) |-> idx_reg >= low_pos)
        else $error("leading zero skip passed the integer digits");
`endif

endmodule

/* sv/abbreviated_count_formatter.sv */
// Abbreviated count formatter: signed count in, short decimal ASCII text out.
//
// Input channel: in_valid / in_stall with count_value, a signed count of
// VALUE_BITS bits. Output channel: out_valid / out_stall with char_code (one
// ASCII character per item) and last_char, high on the final character of a
// count's text. Counts of 1000 and up come out as integer part, '.', one
// rounded tenths digit and 'K', 'M' or 'B'; smaller or negative counts come
// out in full decimal with '-' when negative.
// The back part sets the pace: it takes a count from the queue, converts it
// bit-serially from binary to decimal, skips leading zero digits and then
// emits the characters. It works on one count at a time; a two-entry queue
// lets new counts be taken while text is sent.
// Reset clears all valid flags and returns the sequencer to idle; no item is
// lost or repeated while out_stall is high, the pending character is held.
module abbreviated_count_formatter
    import acf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] count_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [6:0]            char_code,
    output logic                  last_char
);

    logic                  push;
    ctl_t                  push_ctl;
    logic [VALUE_BITS-1:0] push_value;
    logic                  q_full;
    logic                  pop;
    logic                  q_valid;
    ctl_t                  q_ctl;
    logic [VALUE_BITS-1:0] q_value;

    acf_front #(.VB(VALUE_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .count_value (count_value),
        .q_full      (q_full),
        .q_push      (push),
        .q_ctl       (push_ctl),
        .q_value     (push_value)
    );

    acf_queue #(.VB(VALUE_BITS)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ctl   (push_ctl),
        .push_value (push_value),
        .full       (q_full),
        .pop        (pop),
        .rd_valid   (q_valid),
        .rd_ctl     (q_ctl),
        .rd_value   (q_value)
    );

    acf_back #(.VB(VALUE_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (pop),
        .q_ctl     (q_ctl),
        .q_value   (q_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

endmodule

/* bench/abbreviated_count_formatter_test.sv */
// Self-checking testbench for the abbreviated count formatter: random and directed counts.
`timescale 1ns / 1ps

module abbreviated_count_formatter_test;
    import acf_pkg::*;

    localparam int VALUE_BITS  = VALUE_BITS_DEF;
    localparam int RANDOM_ITEMS = 245;
    localparam int STUCK_LIMIT = 5000;
    localparam int TAIL_CYCLES = 150;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic [6:0] code;
        logic       last;
    } char_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [VALUE_BITS-1:0] count_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [6:0]            char_code;
    logic                  last_char;

    logic [VALUE_BITS-1:0] pending_counts [$];
    char_item_t            expected_chars [$];

    int  items_taken = 0;
    int  chars_checked = 0;
    int  mismatches = 0;
    int  stuck_cycles = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  draining = 1'b0;
    bit  in_fire = 1'b0;
    bit  out_fire = 1'b0;

    // No idling on either side for a stretch in the middle of the run.
    wire quiet = items_taken >= 120 && items_taken < 180;

    abbreviated_count_formatter #(.VALUE_BITS(VALUE_BITS)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .count_value (count_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_code   (char_code),
        .last_char   (last_char)
    );

    always #2 clk = ~clk;

    // Queue the characters that one count should produce.
    function automatic void format_count(input logic [VALUE_BITS-1:0] value);
        logic [63:0] raw;
        logic [63:0] mag;
        logic [63:0] unit;
        logic [63:0] tenths;
        logic [63:0] rem;
        logic [6:0]  suffix;
        tier_t       tier;
        string       text;
        byte         ch;
        char_item_t  item;
        raw = {{(64-VALUE_BITS){1'b0}}, value};
        if (value[VALUE_BITS-1])
        begin
            mag = {{(64-VALUE_BITS){1'b0}}, -value};
            if (mag > NEG_MAG_LIMIT)
                mag = NEG_MAG_LIMIT;
            text = $sformatf("%c%0d", CHAR_MINUS, mag);
        end
        else if (raw < TIER_K_MIN)
        begin
            text = $sformatf("%0d", raw);
        end
        else
        begin
            if (raw >= TIER_B_MIN)
                tier = TIER_B;
            else if (raw >= TIER_M_MIN)
                tier = TIER_M;
            else
                tier = TIER_K;
            case (tier)
                TIER_B:  begin unit = 64'd100000000; suffix = CHAR_B; end
                TIER_M:  begin unit = 64'd100000;    suffix = CHAR_M; end
                default: begin unit = 64'd100;       suffix = CHAR_K; end
            endcase
            tenths = raw / unit;
            rem = raw % unit;
            // Round the tenths half up.
            if (rem * 2 >= unit)
                tenths = tenths + 1;
            text = $sformatf("%0d.%0d%c", tenths / 10, tenths % 10, suffix);
        end
        for (int i = 0; i < text.len(); i++)
        begin
            ch = text[i];
            item.code = ch[6:0];
            item.last = (i == text.len() - 1);
            expected_chars = {expected_chars, item};
        end
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand_below(input logic [63:0] span);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return VALUE_BITS'(r % span);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endtask

    // Sender: hold the payload while stalled, advance on acceptance.
    always @(negedge clk)
    begin : sender
        bit offer;
        if (rst_n)
        begin
            if (in_fire)
            begin
                void'(pending_counts.pop_front());
                if (items_taken == 60 || items_taken == 200)
                    draining = 1'b1;
            end
            if (draining && expected_chars.size() == 0)
                draining = 1'b0;
            if (!(in_valid && !in_fire))
            begin
                offer = pending_counts.size() != 0 && !draining
                        && (quiet || $urandom_range(99) >= 25);
                in_valid <= offer;
                if (offer)
                    count_value <= pending_counts[0];
            end
        end
    end

    // Receiver: random stalls plus one long hold-off that backs up the input.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && items_taken >= 230)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && $urandom_range(99) < 25;
        end
    end

    // Monitor: predict on input acceptance, check on output acceptance.
    always @(posedge clk)
    begin : monitor
        char_item_t want;
        in_fire = rst_n && in_valid && !in_stall;
        out_fire = rst_n && out_valid && !out_stall;
        if (in_fire)
        begin
            format_count(count_value);
            items_taken++;
        end
        if (out_fire)
        begin
            chars_checked++;
            if (expected_chars.size() == 0)
                note_mismatch($sformatf("char %0d: nothing expected, got code %h last %b",
                                        chars_checked, char_code, last_char));
            else
            begin
                want = expected_chars.pop_front();
                if (char_code !== want.code || last_char !== want.last)
                    note_mismatch($sformatf(
                        "char %0d: expected code %h last %b, got code %h last %b",
                        chars_checked, want.code, want.last, char_code, last_char));
            end
        end
    end

    always @(posedge clk)
    begin
        if (in_fire || out_fire || !rst_n)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        longint directed [25] = '{
            0, 1, 9, 10, 99, 100, 999, 1000, 1049, 1050,
            999949, 999950, 999999, 1000000, 1049999, 1050000,
            999999999, 1000000000, 64'sd140737488355327,
            -1, -9, -999, -1000, -64'sd140737488355328, -64'sd140737488355327
        };
        logic [63:0]           unit;
        logic [63:0]           t;
        logic [VALUE_BITS-1:0] v;
        foreach (directed[i])
            pending_counts = {pending_counts, directed[i][VALUE_BITS-1:0]};
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(7))
                0: v = VALUE_BITS'($urandom_range(999));
                1: v = 1000 + rand_below(64'd999000);
                2: v = 1000000 + rand_below(64'd999000000);
                3: v = 1000000000 + rand_below(64'd140736488355328);
                4:
                begin
                    // Land on or next to a rounding tie.
                    case ($urandom_range(2))
                        0: begin unit = 64'd100;       t = 10 + rand_below(64'd9990); end
                        1: begin unit = 64'd100000;    t = 10 + rand_below(64'd9990); end
                        default:
                           begin unit = 64'd100000000; t = 10 + rand_below(64'd1400000); end
                    endcase
                    v = VALUE_BITS'(t * unit + unit / 2 - 1 + $urandom_range(2));
                end
                5: v = -VALUE_BITS'(1 + $urandom_range(999));
                6: v = VALUE_BITS'({$urandom, $urandom});
                default: v = -(VALUE_BITS'(1) + rand_below(64'd140737488355328));
            endcase
            pending_counts = {pending_counts, v};
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_counts.size() == 0 && !in_valid);
        wait (expected_chars.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Formatted %0d counts (all tiers, ties, negatives) into %0d characters,",
                 items_taken, chars_checked);
        $display("with a long output hold-off and two drain pauses; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && expected_chars.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
